// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/burb_pkg.sv
`default_nettype none

package burb_pkg;

    // Register window
    localparam logic [15:0] WIN_LO   = 16'h2188;
    localparam logic [15:0] WIN_END  = 16'h21a0;
    localparam int          NUM_REGS = 24;
    localparam int          REG_IDX_W = $clog2(NUM_REGS);

    // Addresses with side effects or special handling
    localparam logic [15:0] ADDR_CALC    = 16'h218f;
    localparam logic [15:0] ADDR_REC_RST = 16'h2191;
    localparam logic [15:0] ADDR_RECORD  = 16'h2192;
    localparam logic [15:0] ADDR_MASKED  = 16'h2193;

    // Register indexes touched by the side effects
    localparam logic [REG_IDX_W-1:0] IDX_ACC_LO = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] IDX_ACC_HI = REG_IDX_W'(7);
    localparam logic [REG_IDX_W-1:0] IDX_STORE  = REG_IDX_W'(8);

    localparam logic [7:0] MASKED_RD_MASK = 8'hf3;

    // Time record
    localparam int TIME_RECORD_LEN_DEF = 18;
    localparam int REC_POS_ONE_A = 5;
    localparam int REC_POS_ONE_B = 6;
    localparam int REC_POS_SEC   = 10;
    localparam int REC_POS_MIN   = 11;
    localparam int REC_POS_HOUR  = 12;

    // Access kind carried in tuser
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Field widths
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    localparam int ADDR_LSB = 0;
    localparam int WDATA_LSB = ADDR_LSB + ADDR_W;
    localparam int HOUR_LSB = WDATA_LSB + DATA_W;
    localparam int MIN_LSB  = HOUR_LSB + HOUR_W;
    localparam int SEC_LSB  = MIN_LSB + MIN_W;

endpackage

`default_nettype wire

// File: rtl/core/base_unit_register_block.sv
// Pipeline: an input transaction is captured in the input register, then its result in the
// result register, which drives the result transaction.
// Throughput: one transaction per cycle while the output is not stalled; the single-pass logic
// between the two registers handles any access, including the time record walk.
// Reset: synchronous, active low; clears the register file, record position, latched
// time and both valid flags to zero.
`default_nettype none

`include "assert_macros.svh"

module base_unit_register_block #(
    parameter int TIME_RECORD_LEN = burb_pkg::TIME_RECORD_LEN_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] address, [23:16] write_data, [28:24] now_hour,
    // [34:29] now_minute, [40:35] now_second, [47:41] zero
    input  wire logic [burb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] func
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] read_data
    output logic [burb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // [0] outside_window
    output logic                                m_axis_tuser
);

    localparam int POS_W = $clog2(TIME_RECORD_LEN);

    // input stage
    logic                               r_in_valid;
    logic                               r_in_func;
    logic [burb_pkg::ADDR_W-1:0]        r_in_addr;
    logic [burb_pkg::DATA_W-1:0]        r_in_wdata;
    logic [burb_pkg::HOUR_W-1:0]        r_in_hour;
    logic [burb_pkg::MIN_W-1:0]         r_in_min;
    logic [burb_pkg::SEC_W-1:0]         r_in_sec;

    // result stage
    logic                               r_out_valid;
    logic [burb_pkg::DATA_W-1:0]        r_out_rdata;
    logic                               r_out_outside;

    // block state
    logic [burb_pkg::DATA_W-1:0]        r_regs [burb_pkg::NUM_REGS];
    logic [POS_W-1:0]                   r_rec_pos;
    logic [burb_pkg::HOUR_W-1:0]        r_lat_hour;
    logic [burb_pkg::MIN_W-1:0]         r_lat_min;
    logic [burb_pkg::SEC_W-1:0]         r_lat_sec;

    logic [burb_pkg::DATA_W-1:0]        n_regs [burb_pkg::NUM_REGS];
    logic [POS_W-1:0]                   n_rec_pos;
    logic                               n_latch;
    logic [burb_pkg::DATA_W-1:0]        n_rdata;
    logic                               n_outside;

    logic                               out_adv;
    logic                               proc;
    logic [burb_pkg::REG_IDX_W-1:0]     idx;
    logic [POS_W:0]                     pos_inc;
    logic [burb_pkg::DATA_W-1:0]        rec_byte;
    logic [burb_pkg::DATA_W-1:0]        acc_half;

    assign out_adv       = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && out_adv;
    assign s_axis_tready = !r_in_valid || out_adv;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_rdata;
    assign m_axis_tuser  = r_out_outside;

    assign n_outside = (r_in_addr < burb_pkg::WIN_LO) || (r_in_addr >= burb_pkg::WIN_END);
    assign idx       = burb_pkg::REG_IDX_W'(r_in_addr - burb_pkg::WIN_LO);
    assign pos_inc   = {1'b0, r_rec_pos} + (POS_W+1)'(1);
    assign acc_half  = r_regs[burb_pkg::IDX_ACC_LO] >> 1;

    // time record byte at the current position
    always_comb begin
        case (r_rec_pos)
            POS_W'(burb_pkg::REC_POS_ONE_A),
            POS_W'(burb_pkg::REC_POS_ONE_B): rec_byte = burb_pkg::DATA_W'(1);
            POS_W'(burb_pkg::REC_POS_SEC):   rec_byte = burb_pkg::DATA_W'(r_lat_sec);
            POS_W'(burb_pkg::REC_POS_MIN):   rec_byte = burb_pkg::DATA_W'(r_lat_min);
            POS_W'(burb_pkg::REC_POS_HOUR):  rec_byte = burb_pkg::DATA_W'(r_lat_hour);
            default:                         rec_byte = '0;
        endcase
    end

    always_comb begin
        n_regs    = r_regs;
        n_rec_pos = r_rec_pos;
        n_latch   = 1'b0;
        n_rdata   = '0;
        if (!n_outside) begin
            if (r_in_func == burb_pkg::FUNC_READ) begin
                case (r_in_addr)
                    burb_pkg::ADDR_RECORD: begin
                        n_rdata   = rec_byte;
                        n_latch   = (r_rec_pos == '0);
                        n_rec_pos = (pos_inc >= (POS_W+1)'(TIME_RECORD_LEN)) ?
                                    '0 : pos_inc[POS_W-1:0];
                    end
                    burb_pkg::ADDR_MASKED: begin
                        n_rdata = r_regs[idx] & burb_pkg::MASKED_RD_MASK;
                    end
                    default: begin
                        n_rdata = r_regs[idx];
                    end
                endcase
            end else begin
                case (r_in_addr)
                    burb_pkg::ADDR_CALC: begin
                        // data byte is ignored here
                        n_regs[burb_pkg::IDX_ACC_LO] = r_regs[burb_pkg::IDX_ACC_HI] - acc_half;
                        n_regs[burb_pkg::IDX_ACC_HI] = r_regs[burb_pkg::IDX_ACC_HI] >> 1;
                    end
                    burb_pkg::ADDR_REC_RST: begin
                        n_regs[idx] = r_in_wdata;
                        n_rec_pos   = '0;
                    end
                    burb_pkg::ADDR_RECORD: begin
                        n_regs[burb_pkg::IDX_STORE] = r_in_wdata;
                    end
                    default: begin
                        n_regs[idx] = r_in_wdata;
                    end
                endcase
            end
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rec_pos   <= '0;
            r_lat_hour  <= '0;
            r_lat_min   <= '0;
            r_lat_sec   <= '0;
            for (int i = 0; i < burb_pkg::NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (proc) begin
                r_regs    <= n_regs;
                r_rec_pos <= n_rec_pos;
                if (n_latch) begin
                    r_lat_hour <= r_in_hour;
                    r_lat_min  <= r_in_min;
                    r_lat_sec  <= r_in_sec;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func  <= s_axis_tuser;
            r_in_addr  <= s_axis_tdata[burb_pkg::ADDR_LSB +: burb_pkg::ADDR_W];
            r_in_wdata <= s_axis_tdata[burb_pkg::WDATA_LSB +: burb_pkg::DATA_W];
            r_in_hour  <= s_axis_tdata[burb_pkg::HOUR_LSB +: burb_pkg::HOUR_W];
            r_in_min   <= s_axis_tdata[burb_pkg::MIN_LSB +: burb_pkg::MIN_W];
            r_in_sec   <= s_axis_tdata[burb_pkg::SEC_LSB +: burb_pkg::SEC_W];
        end
        if (proc) begin
            r_out_rdata   <= n_rdata;
            r_out_outside <= n_outside;
        end
    end

    `ASSERT_IMPL(a_pos_in_range, i_clk, i_rst_n, 1'b1,
        {1'b0, r_rec_pos} < (POS_W+1)'(TIME_RECORD_LEN))
    `ASSERT_IMPL(a_outside_reads_zero, i_clk, i_rst_n, r_out_valid && r_out_outside,
        r_out_rdata == '0)
    `ASSERT_NEXT(a_write_reads_zero, i_clk, i_rst_n,
        proc && (r_in_func == burb_pkg::FUNC_WRITE), m_axis_tdata == '0)

endmodule

`default_nettype wire
